@@ rtl/seven_segment_value_formatter_defines.svh @@
// Assertion macros for the seven-segment value formatter.
// Used by the top level only; no other dependencies.
`ifndef SEVEN_SEGMENT_VALUE_FORMATTER_DEFINES_SVH
`define SEVEN_SEGMENT_VALUE_FORMATTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SVF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SVF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/svf_pkg.sv @@
// Shared types, constants and segment tables for the seven-segment value formatter.
// No dependencies.
package svf_pkg;

    typedef enum logic [1:0] {
        OP_VALUE = 2'd0,
        OP_SC    = 2'd1,
        OP_ERR   = 2'd2
    } t_op;

    localparam int OpWidth    = 2;
    localparam int ValueWidth = 17;
    localparam int SelWidth   = 2;
    localparam int MaskWidth  = 24;

    // Rounded value path: y = x + 5 or x + 50, fits 18 bits.
    localparam int YWidth    = ValueWidth + 1;
    localparam int ProdWidth = 2 * YWidth;

    // Values at or above this (10.000 units) are shown in tenths.
    localparam logic [ValueWidth-1:0] TenUnits = 17'd10000;
    localparam logic [YWidth-1:0]     RoundHundredths = 18'd5;
    localparam logic [YWidth-1:0]     RoundTenths     = 18'd50;

    // Reciprocals: floor(y / d) = (y * m) >> k, exact for all 18-bit y in use.
    localparam logic [YWidth-1:0] Recip10    = 18'd209716;
    localparam logic [YWidth-1:0] Recip100   = 18'd167773;
    localparam logic [YWidth-1:0] Recip1000  = 18'd134218;
    localparam logic [YWidth-1:0] Recip10000 = 18'd214749;
    localparam int Shift10    = 21;
    localparam int Shift100   = 24;
    localparam int Shift1000  = 27;
    localparam int Shift10000 = 31;

    localparam logic [7:0] SegDp     = 8'h80;
    localparam logic [7:0] SegBlank  = 8'h00;
    localparam logic [7:0] TagScMid  = 8'hED;
    localparam logic [7:0] TagScRgt  = 8'hB9;
    localparam logic [7:0] TagErrLft = 8'h79;
    localparam logic [7:0] TagErrMid = 8'h50;
    localparam logic [7:0] TagErrRgt = 8'hD0;

    typedef struct packed {
        logic [3:0] d0;        // left digit
        logic [3:0] d1;        // middle digit
        logic [3:0] d2;        // right digit
        logic       below_ten; // point after left digit, else after middle
    } t_digits;

    typedef logic [4:0] t_bit_pos;
    typedef t_bit_pos t_pos_row [8];

    // Board wiring: mask bit for segments a..g and dp, per digit position.
    localparam t_pos_row PosMap [3] = '{
        '{5'd14, 5'd15, 5'd9,  5'd10, 5'd11, 5'd13, 5'd12, 5'd8},
        '{5'd17, 5'd19, 5'd7,  5'd6,  5'd4,  5'd16, 5'd18, 5'd5},
        '{5'd20, 5'd21, 5'd3,  5'd1,  5'd0,  5'd22, 5'd23, 5'd2}
    };

    function automatic logic [7:0] digit_segments(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [MaskWidth-1:0] place_pattern(input int pos,
                                                           input logic [7:0] pattern);
        logic [MaskWidth-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (pattern[i]) begin
                m[PosMap[pos][i]] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

@@ rtl/seven_segment_value_formatter.sv @@
// Seven-segment value formatter: request in, 24-bit segment mask out.
// Depends on svf_pkg, svf_digits, svf_seg_map and the defines header.
//
// Usage:
//   Input channel i_valid / o_stall carries one request: i_operation (value,
//   SC tag or Err tag), i_value_milli in thousandths, i_display_select.
//   Output channel o_valid / i_stall returns o_segment_mask and
//   o_display_select_out. A request moves on any edge with valid high and
//   stall low.
//   Stages: request register, then formatting logic into the result register.
//   One request per cycle is sustained while i_stall is low; the path is
//   bounded by four parallel 18x18 constant multiplies and a short subtract.
//   When the receiver stalls, the result register holds; a second request
//   waits in the request register, and o_stall rises only when both hold.
//   Synchronous reset (i_rst_n low) empties both registers; no results are
//   pending afterward.
module seven_segment_value_formatter
    import svf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [OpWidth-1:0]   i_operation,
    input  logic [ValueWidth-1:0] i_value_milli,
    input  logic [SelWidth-1:0]  i_display_select,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [MaskWidth-1:0] o_segment_mask,
    output logic [SelWidth-1:0]  o_display_select_out
);

    logic                  r_in_valid;
    logic [OpWidth-1:0]    r_op;
    logic [ValueWidth-1:0] r_value;
    logic [SelWidth-1:0]   r_sel;
    logic                  r_out_valid;
    logic [MaskWidth-1:0]  r_mask;
    logic [SelWidth-1:0]   r_sel_out;

    logic                  out_adv;
    logic                  in_adv;
    t_digits               digits;
    logic [MaskWidth-1:0]  n_mask;

    assign out_adv = !r_out_valid || !i_stall;
    assign in_adv  = !r_in_valid || out_adv;
    assign o_stall = !in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_valid) begin
            r_op    <= i_operation;
            r_value <= i_value_milli;
            r_sel   <= i_display_select;
        end
        if (out_adv && r_in_valid) begin
            r_mask    <= n_mask;
            r_sel_out <= r_sel;
        end
    end

    svf_digits u_digits (
        .i_value_milli (r_value),
        .o_digits      (digits)
    );

    svf_seg_map u_seg_map (
        .i_operation    (r_op),
        .i_digits       (digits),
        .o_segment_mask (n_mask)
    );

    assign o_valid              = r_out_valid;
    assign o_segment_mask       = r_mask;
    assign o_display_select_out = r_sel_out;

`include "seven_segment_value_formatter_defines.svh"

    `SVF_ASSERT_NEXT(a_req_moves_out, i_clk, i_rst_n, r_in_valid && out_adv, o_valid, "request lost between stages")
    `SVF_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall, r_in_valid && r_out_valid && i_stall, "stall while a stage is free")
    `SVF_ASSERT_NEXT(a_drain_empties, i_clk, i_rst_n, o_valid && !i_stall && !r_in_valid, !o_valid, "result repeated after delivery")

endmodule

@@ rtl/svf_digits.sv @@
// Value to three decimal digits: rounding and digit split by constant reciprocals.
// Depends on svf_pkg.
module svf_digits
    import svf_pkg::*;
(
    input  logic [ValueWidth-1:0] i_value_milli,
    output t_digits               o_digits
);

    logic                 below_ten;
    logic [YWidth-1:0]    y;
    logic [ProdWidth-1:0] p10, p100, p1000, p10000;
    logic [13:0]          s10;
    logic [10:0]          s100;
    logic [7:0]           s1000;
    logic [3:0]           s10000;
    logic [13:0]          scaled;
    logic [10:0]          q10;
    logic [7:0]           q100;
    logic [13:0]          d2_full;
    logic [10:0]          d1_full;
    logic [7:0]           d0_full;

    assign below_ten = i_value_milli < TenUnits;
    assign y = {1'b0, i_value_milli} + (below_ten ? RoundHundredths : RoundTenths);

    // Four independent constant multiplies.
    assign p10    = ProdWidth'(y) * ProdWidth'(Recip10);
    assign p100   = ProdWidth'(y) * ProdWidth'(Recip100);
    assign p1000  = ProdWidth'(y) * ProdWidth'(Recip1000);
    assign p10000 = ProdWidth'(y) * ProdWidth'(Recip10000);

    assign s10    = p10[Shift10+13:Shift10];
    assign s100   = p100[Shift100+10:Shift100];
    assign s1000  = p1000[Shift1000+7:Shift1000];
    assign s10000 = p10000[Shift10000+3:Shift10000];

    always_comb begin
        if (below_ten) begin
            scaled = s10;
            q10    = s100;
            q100   = s1000;
        end else begin
            scaled = {3'b000, s100};
            q10    = {3'b000, s1000};
            q100   = {4'b0000, s10000};
        end
    end

    // Remainders: n - 10 * floor(n / 10).
    assign d2_full = scaled - ({q10, 3'b000} + {2'b00, q10, 1'b0});
    assign d1_full = q10 - ({q100, 3'b000} + {2'b00, q100, 1'b0});
    assign d0_full = (q100 >= 8'd10) ? (q100 - 8'd10) : q100;

    assign o_digits.d0        = d0_full[3:0];
    assign o_digits.d1        = d1_full[3:0];
    assign o_digits.d2        = d2_full[3:0];
    assign o_digits.below_ten = below_ten;

endmodule

@@ rtl/svf_seg_map.sv @@
// Digits or tag to the board-mapped 24-bit segment mask.
// Depends on svf_pkg.
module svf_seg_map
    import svf_pkg::*;
(
    input  logic [OpWidth-1:0]   i_operation,
    input  t_digits              i_digits,
    output logic [MaskWidth-1:0] o_segment_mask
);

    logic [7:0] pat0, pat1, pat2;

    always_comb begin
        case (i_operation)
            OP_VALUE: begin
                pat0 = digit_segments(i_digits.d0) | (i_digits.below_ten ? SegDp : SegBlank);
                pat1 = digit_segments(i_digits.d1) | (i_digits.below_ten ? SegBlank : SegDp);
                pat2 = digit_segments(i_digits.d2);
            end
            OP_SC: begin
                pat0 = SegBlank;
                pat1 = TagScMid;
                pat2 = TagScRgt;
            end
            OP_ERR: begin
                pat0 = TagErrLft;
                pat1 = TagErrMid;
                pat2 = TagErrRgt;
            end
            default: begin
                pat0 = SegBlank;
                pat1 = SegBlank;
                pat2 = SegBlank;
            end
        endcase
    end

    assign o_segment_mask = place_pattern(0, pat0) | place_pattern(1, pat1)
                          | place_pattern(2, pat2);

endmodule
